/* design/agn_pkg.sv */
// Package for the audio noise gate: controller states, multiplier operand
// selects, register indexes, register reset values and the command bundle.
// No dependencies; every other design file imports it.
package agn_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENV_A,
    ST_ENV_B,
    ST_ENV_C,
    ST_GATE,
    ST_GAIN_MUL,
    ST_GAIN_UPD,
    ST_OUT_MUL,
    ST_OUT_FMT
  } agn_state_t;

  typedef enum logic [1:0] {
    MUL_ENV_OLD,
    MUL_ENV_NEW,
    MUL_GAIN,
    MUL_OUT
  } agn_mul_op_t;

  typedef enum logic [2:0] {
    REG_GATE_ENABLE  = 3'd0,
    REG_OPEN_THRESH  = 3'd1,
    REG_CLOSE_THRESH = 3'd2,
    REG_ATTACK_COEF  = 3'd3,
    REG_RELEASE_COEF = 3'd4,
    REG_HOLD_LENGTH  = 3'd5
  } agn_reg_idx_t;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_DATA_W-1:0] OPEN_THRESH_RST  = 32'd83886;
  localparam logic [CFG_DATA_W-1:0] CLOSE_THRESH_RST = 32'd41943;
  localparam logic [CFG_DATA_W-1:0] ATTACK_COEF_RST  = 32'd16000000;
  localparam logic [CFG_DATA_W-1:0] RELEASE_COEF_RST = 32'd16700000;

  typedef struct packed {
    logic        load;
    agn_mul_op_t mul_op;
    logic        acc_ld;
    logic        env_ld;
    logic        gate_upd;
    logic        gain_upd;
    logic        out_ld;
  } agn_cmd_t;

endpackage

/* design/agn_regs.sv */
// Configuration register file of the noise gate behind an APB-style port.
// Any write to a listed register also requests a state reinitialization.
// Depends on agn_pkg.
module agn_regs #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 24,
  parameter int HOLD_BITS   = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [agn_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [agn_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [agn_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             gate_enable,
  output logic [SAMPLE_BITS-1:0]           open_thresh,
  output logic [SAMPLE_BITS-1:0]           close_thresh,
  output logic [COEF_BITS-1:0]             attack_coef,
  output logic [COEF_BITS-1:0]             release_coef,
  output logic [HOLD_BITS-1:0]             hold_length,
  output logic                             init_req,
  output logic                             init_enable
);
  import agn_pkg::*;

  logic                   enable_r;
  logic [SAMPLE_BITS-1:0] open_r;
  logic [SAMPLE_BITS-1:0] close_r;
  logic [COEF_BITS-1:0]   attack_r;
  logic [COEF_BITS-1:0]   release_r;
  logic [HOLD_BITS-1:0]   hold_r;
  logic                   wr;
  logic                   known;
  agn_reg_idx_t           idx;

  assign idx = agn_reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr  = psel & penable & pwrite;

  always_comb begin
    known  = 1'b1;
    prdata = '0;
    case (idx)
      REG_GATE_ENABLE:  prdata = CFG_DATA_W'(enable_r);
      REG_OPEN_THRESH:  prdata = CFG_DATA_W'(open_r);
      REG_CLOSE_THRESH: prdata = CFG_DATA_W'(close_r);
      REG_ATTACK_COEF:  prdata = CFG_DATA_W'(attack_r);
      REG_RELEASE_COEF: prdata = CFG_DATA_W'(release_r);
      REG_HOLD_LENGTH:  prdata = CFG_DATA_W'(hold_r);
      default:          known  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      open_r    <= OPEN_THRESH_RST[SAMPLE_BITS-1:0];
      close_r   <= CLOSE_THRESH_RST[SAMPLE_BITS-1:0];
      attack_r  <= ATTACK_COEF_RST[COEF_BITS-1:0];
      release_r <= RELEASE_COEF_RST[COEF_BITS-1:0];
      hold_r    <= '0;
    end else if (wr) begin
      case (idx)
        REG_GATE_ENABLE:  enable_r  <= pwdata[0];
        REG_OPEN_THRESH:  open_r    <= pwdata[SAMPLE_BITS-1:0];
        REG_CLOSE_THRESH: close_r   <= pwdata[SAMPLE_BITS-1:0];
        REG_ATTACK_COEF:  attack_r  <= pwdata[COEF_BITS-1:0];
        REG_RELEASE_COEF: release_r <= pwdata[COEF_BITS-1:0];
        REG_HOLD_LENGTH:  hold_r    <= pwdata[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign init_req     = wr & known;
  assign init_enable  = (idx == REG_GATE_ENABLE) ? pwdata[0] : enable_r;
  assign gate_enable  = enable_r;
  assign open_thresh  = open_r;
  assign close_thresh = close_r;
  assign attack_coef  = attack_r;
  assign release_coef = release_r;
  assign hold_length  = hold_r;

endmodule

/* design/agn_ctrl.sv */
// Sequencing controller of the noise gate: steps one sample through the
// shared-multiplier datapath and owns the input ready and output valid.
// Depends on agn_pkg.
module agn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              gate_enable,
  output agn_pkg::agn_cmd_t cmd
);
  import agn_pkg::*;

  agn_state_t state_r;
  agn_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       in_fire;
  logic       out_free;

  assign in_fire  = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = gate_enable ? ST_ENV_A : ST_OUT_FMT;
        end
      end
      ST_ENV_A:     state_nxt = ST_ENV_B;
      ST_ENV_B:     state_nxt = ST_ENV_C;
      ST_ENV_C:     state_nxt = ST_GATE;
      ST_GATE:      state_nxt = ST_GAIN_MUL;
      ST_GAIN_MUL:  state_nxt = ST_GAIN_UPD;
      ST_GAIN_UPD:  state_nxt = ST_OUT_MUL;
      ST_OUT_MUL:   state_nxt = ST_OUT_FMT;
      ST_OUT_FMT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.mul_op = MUL_OUT;
    in_ready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_ENV_A:    cmd.mul_op = MUL_ENV_OLD;
      ST_ENV_B: begin
        cmd.mul_op = MUL_ENV_NEW;
        cmd.acc_ld = 1'b1;
      end
      ST_ENV_C:    cmd.env_ld = 1'b1;
      ST_GATE:     cmd.gate_upd = 1'b1;
      ST_GAIN_MUL: cmd.mul_op = MUL_GAIN;
      ST_GAIN_UPD: cmd.gain_upd = 1'b1;
      ST_OUT_MUL:  cmd.mul_op = MUL_OUT;
      ST_OUT_FMT:  cmd.out_ld = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ready;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("Accepted sample did not start processing.");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |=> out_valid_r)
    else $error("Result register load did not raise out valid.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid_r || out_ready))
    else $error("Result register overwritten before transfer.");

endmodule

/* design/agn_dp.sv */
// Datapath of the noise gate: envelope, gate/hold state, gain and output
// formatting around one shared registered multiplier. Driven by agn_ctrl.
// Depends on agn_pkg.
module agn_dp #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 24,
  parameter int HOLD_BITS   = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  agn_pkg::agn_cmd_t      cmd,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  output logic [SAMPLE_BITS-1:0] sample_out,
  input  logic                   gate_enable,
  input  logic [SAMPLE_BITS-1:0] open_thresh,
  input  logic [SAMPLE_BITS-1:0] close_thresh,
  input  logic [COEF_BITS-1:0]   attack_coef,
  input  logic [COEF_BITS-1:0]   release_coef,
  input  logic [HOLD_BITS-1:0]   hold_length,
  input  logic                   init_req,
  input  logic                   init_enable
);
  import agn_pkg::*;

  localparam int OPW = ((SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS) + 1;
  localparam int PW  = 2 * OPW;
  localparam logic [COEF_BITS:0] ONE = {1'b1, {COEF_BITS{1'b0}}};

  logic [SAMPLE_BITS-1:0] raw_r;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic                   neg_r;
  logic                   bypass_r;
  logic [COEF_BITS-1:0]   coef_r;
  logic [SAMPLE_BITS-1:0] env_r;
  logic [COEF_BITS:0]     gain_r;
  logic                   open_r;
  logic [HOLD_BITS-1:0]   hold_r;
  logic [PW-1:0]          prod_r;
  logic [PW-1:0]          acc_r;
  logic [SAMPLE_BITS-1:0] out_r;

  logic [SAMPLE_BITS-1:0] mag_in;
  logic [COEF_BITS:0]     one_minus_c;
  logic [OPW-1:0]         mul_a;
  logic [OPW-1:0]         mul_b;
  logic [PW-1:0]          env_sum;
  logic [SAMPLE_BITS-1:0] q_floor;
  logic                   frac_nz;
  logic [SAMPLE_BITS-1:0] res;
  logic                   open_nxt;
  logic [HOLD_BITS-1:0]   hold_nxt;

  assign mag_in      = sample_in[SAMPLE_BITS-1] ? (~sample_in + SAMPLE_BITS'(1)) : sample_in;
  assign one_minus_c = ONE - {1'b0, coef_r};

  always_comb begin
    mul_a = OPW'(mag_r);
    mul_b = OPW'(gain_r);
    case (cmd.mul_op)
      MUL_ENV_OLD: begin
        mul_a = OPW'(coef_r);
        mul_b = OPW'(env_r);
      end
      MUL_ENV_NEW: begin
        mul_a = OPW'(one_minus_c);
        mul_b = OPW'(mag_r);
      end
      MUL_GAIN: begin
        mul_a = open_r ? OPW'(one_minus_c) : OPW'(coef_r);
        mul_b = open_r ? OPW'(ONE - gain_r) : OPW'(gain_r);
      end
      MUL_OUT: begin
        mul_a = OPW'(mag_r);
        mul_b = OPW'(gain_r);
      end
      default: ;
    endcase
  end

  assign env_sum = acc_r + prod_r;

  always_comb begin
    open_nxt = open_r;
    hold_nxt = hold_r;
    if (!open_r) begin
      if (env_r >= open_thresh) begin
        open_nxt = 1'b1;
        hold_nxt = hold_length;
      end
    end else if (env_r >= close_thresh) begin
      hold_nxt = hold_length;
    end else if (hold_r != '0) begin
      hold_nxt = hold_r - HOLD_BITS'(1);
    end else begin
      open_nxt = 1'b0;
    end
  end

  // Negative results round the magnitude up so the signed product floors.
  assign q_floor = prod_r[COEF_BITS +: SAMPLE_BITS];
  assign frac_nz = |prod_r[COEF_BITS-1:0];

  always_comb begin
    if (bypass_r) begin
      res = raw_r;
    end else if (neg_r) begin
      res = SAMPLE_BITS'(0) - (q_floor + SAMPLE_BITS'(frac_nz));
    end else begin
      res = q_floor;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a) * PW'(mul_b);
    if (cmd.load) begin
      raw_r    <= sample_in;
      mag_r    <= mag_in;
      neg_r    <= sample_in[SAMPLE_BITS-1];
      bypass_r <= ~gate_enable;
      coef_r   <= (mag_in > env_r) ? attack_coef : release_coef;
    end else if (cmd.gate_upd) begin
      coef_r <= (open_nxt && (gain_r < ONE)) ? attack_coef : release_coef;
    end
    if (cmd.acc_ld) begin
      acc_r <= prod_r;
    end
    if (cmd.out_ld) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r  <= '0;
      hold_r <= '0;
      gain_r <= ONE;
      open_r <= 1'b1;
    end else if (init_req) begin
      env_r  <= '0;
      hold_r <= '0;
      gain_r <= init_enable ? '0 : ONE;
      open_r <= ~init_enable;
    end else begin
      if (cmd.env_ld) begin
        env_r <= env_sum[COEF_BITS +: SAMPLE_BITS];
      end
      if (cmd.gate_upd) begin
        open_r <= open_nxt;
        hold_r <= hold_nxt;
      end
      if (cmd.gain_upd) begin
        gain_r <= open_r ? (gain_r + prod_r[COEF_BITS +: COEF_BITS+1])
                         : prod_r[COEF_BITS +: COEF_BITS+1];
      end
    end
  end

  assign sample_out = out_r;

  a_gain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= ONE)
    else $error("Gate gain exceeds unity.");

  a_closed_gain_falls: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.gain_upd && !open_r && !init_req) |=> gain_r <= $past(gain_r))
    else $error("Gain rose while the gate was closed.");

  a_bypass_keeps_env: assert property (@(posedge clk) disable iff (!rst_n)
    (bypass_r && !init_req) |=> (bypass_r && !$past(cmd.load)) ? $stable(env_r) : 1'b1)
    else $error("Envelope changed on a bypassed sample.");

endmodule

/* design/audio_noise_gate_top.sv */
// Audio noise gate top level. With the gate enabled a sample is accepted,
// processed on one shared multiplier, and presented in the output
// register. Disabled, a sample passes through unchanged. A new sample is
// accepted only after the last one is in the output register. Synchronous
// active-low reset restores register defaults and a disabled, open gate.
module audio_noise_gate_top #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 24,
  parameter int HOLD_BITS   = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // [SAMPLE_BITS-1:0] sample_in
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    out_tdata,  // [SAMPLE_BITS-1:0] sample_out
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [agn_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [agn_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [agn_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import agn_pkg::*;

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  agn_cmd_t               cmd;
  logic                   gate_enable;
  logic [SAMPLE_BITS-1:0] open_thresh;
  logic [SAMPLE_BITS-1:0] close_thresh;
  logic [COEF_BITS-1:0]   attack_coef;
  logic [COEF_BITS-1:0]   release_coef;
  logic [HOLD_BITS-1:0]   hold_length;
  logic                   init_req;
  logic                   init_enable;
  logic [SAMPLE_BITS-1:0] sample_out;

  assign cfg_pready = 1'b1;

  agn_regs #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS),
    .HOLD_BITS  (HOLD_BITS)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .gate_enable (gate_enable),
    .open_thresh (open_thresh),
    .close_thresh(close_thresh),
    .attack_coef (attack_coef),
    .release_coef(release_coef),
    .hold_length (hold_length),
    .init_req    (init_req),
    .init_enable (init_enable)
  );

  agn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .gate_enable(gate_enable),
    .cmd        (cmd)
  );

  agn_dp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS),
    .HOLD_BITS  (HOLD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sample_in   (in_tdata[SAMPLE_BITS-1:0]),
    .sample_out  (sample_out),
    .gate_enable (gate_enable),
    .open_thresh (open_thresh),
    .close_thresh(close_thresh),
    .attack_coef (attack_coef),
    .release_coef(release_coef),
    .hold_length (hold_length),
    .init_req    (init_req),
    .init_enable (init_enable)
  );

  assign out_tdata = TDATA_W'(sample_out);

endmodule

/* dv/tb_audio_noise_gate_top.sv */
// Self-checking testbench for audio_noise_gate_top: stream samples in, predict each gated
// sample with a local fixed-point gate model, and compare every output transfer in order.
// Depends on agn_pkg for register indexes and register reset values.
`timescale 1ns / 1ps

module tb_audio_noise_gate_top;
  import agn_pkg::*;

  localparam logic [63:0] ONE = 64'd1 << 24;
  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RX_HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [23:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  logic gate_en;
  logic [23:0] open_thr;
  logic [23:0] close_thr;
  logic [23:0] atk_coef;
  logic [23:0] rel_coef;
  logic [23:0] hold_len;

  logic [23:0] env_lvl;
  logic [24:0] gain_q;
  logic is_open;
  logic [23:0] hold_cnt;

  logic [23:0] pending_gated[$];
  int n_errors = 0;
  int cyc = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;
  logic rx_hold_go = 1'b0;

  audio_noise_gate_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_hold_go) begin
      rx_hold_left = RX_HOLD_CYCLES;
      rx_hold_go = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Both valid and ready are stable at the falling edge, so a transfer seen here
  // completes at the next rising edge.
  always @(negedge clk) begin
    logic [23:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_gated.size() == 0) begin
        $error("sample_out unexpected transfer, actual %0d", $signed(out_tdata));
        n_errors++;
      end else begin
        want = pending_gated.pop_front();
        if (out_tdata !== want) begin
          $error("sample_out expected %0d actual %0d", $signed(want), $signed(out_tdata));
          n_errors++;
        end
      end
    end
  end

  function automatic void gate_reinit();
    env_lvl = '0;
    hold_cnt = '0;
    gain_q = gate_en ? 25'd0 : ONE[24:0];
    is_open = !gate_en;
  endfunction

  function automatic logic [23:0] gate_sample(input logic [23:0] raw);
    logic [23:0] m24;
    logic [63:0] mag;
    logic [63:0] c;
    logic [63:0] p;
    logic [63:0] q;
    logic neg;
    neg = raw[23];
    m24 = neg ? (~raw + 24'd1) : raw;
    mag = {40'd0, m24};
    if (!gate_en) return raw;
    c = 64'((mag > env_lvl) ? atk_coef : rel_coef);
    env_lvl = 24'((c * env_lvl + (ONE - c) * mag) >> 24);
    if (!is_open) begin
      if (env_lvl >= open_thr) begin
        is_open = 1'b1;
        hold_cnt = hold_len;
      end
    end else if (env_lvl >= close_thr) begin
      hold_cnt = hold_len;
    end else if (hold_cnt != 0) begin
      hold_cnt--;
    end else begin
      is_open = 1'b0;
    end
    if (is_open) begin
      c = 64'((ONE > gain_q) ? atk_coef : rel_coef);
      gain_q = 25'(gain_q + (((ONE - c) * (ONE - gain_q)) >> 24));
    end else begin
      c = 64'(rel_coef);
      gain_q = 25'((c * gain_q) >> 24);
    end
    p = mag * gain_q;
    if (neg) begin
      q = (p >> 24) + 64'(p[23:0] != 0);
      return ~q[23:0] + 24'd1;
    end
    return p[47:24];
  endfunction

  function automatic logic [23:0] pick_coef();
    case ($urandom_range(7))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom);
      default: return 24'(ONE - $urandom_range(1 << 22, 1 << 16));
    endcase
  endfunction

  task automatic send_sample(input logic [23:0] smp);
    logic [23:0] exp_smp;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= smp;
    @(negedge clk);
    while (!in_tready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    exp_smp = gate_sample(smp);
    pending_gated = {pending_gated, exp_smp};
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    logic known;
    known = 1'b1;
    in_tvalid <= 1'b0;
    while (pending_gated.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_GATE_ENABLE: gate_en = val[0];
      REG_OPEN_THRESH: open_thr = val[23:0];
      REG_CLOSE_THRESH: close_thr = val[23:0];
      REG_ATTACK_COEF: atk_coef = val[23:0];
      REG_RELEASE_COEF: rel_coef = val[23:0];
      REG_HOLD_LENGTH: hold_len = val[23:0];
      default: known = 1'b0;
    endcase
    if (known) gate_reinit();
  endtask

  task automatic test_passthrough();
    send_sample(24'h000000);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'hFFFFFF);
    send_sample(24'h000001);
    send_sample(24'h555555);
    send_sample(24'hAAAAAA);
  endtask

  task automatic test_gate_defaults();
    cfg_write(REG_GATE_ENABLE, 32'd1);
    send_sample(24'h800000);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h000000);
    send_sample(24'h000000);
    send_sample(24'hFFFFFF);
  endtask

  task automatic test_gate_extremes();
    cfg_write(REG_OPEN_THRESH, 32'd0);
    cfg_write(REG_CLOSE_THRESH, 32'd0);
    cfg_write(REG_ATTACK_COEF, 32'd0);
    cfg_write(REG_RELEASE_COEF, 32'd16777215);
    cfg_write(REG_HOLD_LENGTH, 32'd0);
    send_sample(24'h800000);
    send_sample(24'h123456);
    send_sample(24'h7FFFFF);
    cfg_write(REG_OPEN_THRESH, 32'd8388608);
    cfg_write(REG_CLOSE_THRESH, 32'd8388608);
    cfg_write(REG_RELEASE_COEF, 32'd0);
    cfg_write(REG_HOLD_LENGTH, 32'd2);
    send_sample(24'h800000);
    // A write to an unmapped register must leave the gate state alone.
    cfg_write(REG_UNUSED, 32'hFFFFFFFF);
    repeat (4) send_sample(24'h000000);
    cfg_write(REG_HOLD_LENGTH, 32'd16777215);
    send_sample(24'h800000);
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    cfg_write(REG_ATTACK_COEF, ATTACK_COEF_RST);
    cfg_write(REG_RELEASE_COEF, RELEASE_COEF_RST);
    rx_hold_go = 1'b1;
    repeat (12) send_sample(24'($urandom));
  endtask

  task automatic test_random_program();
    logic [23:0] m;
    logic [23:0] s;
    logic loud;
    int burst_left;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 87;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 87;
        end
        default: begin
          tx_idle_pct = 23;
          rx_stall_pct = 23;
        end
      endcase
      case ($urandom_range(9))
        0: cfg_write(REG_OPEN_THRESH, 32'd0);
        1: cfg_write(REG_OPEN_THRESH, 32'd8388608);
        default: cfg_write(REG_OPEN_THRESH, $urandom_range(500, 1 << 21));
      endcase
      if ($urandom_range(3) == 0) cfg_write(REG_CLOSE_THRESH, $urandom_range(0, 8388608));
      else cfg_write(REG_CLOSE_THRESH, $urandom_range(0, open_thr));
      cfg_write(REG_ATTACK_COEF, pick_coef());
      cfg_write(REG_RELEASE_COEF, pick_coef());
      case ($urandom_range(9))
        0: cfg_write(REG_HOLD_LENGTH, 32'd16777215);
        1: cfg_write(REG_HOLD_LENGTH, $urandom_range(0, 16777215));
        default: cfg_write(REG_HOLD_LENGTH, $urandom_range(0, 40));
      endcase
      cfg_write(REG_GATE_ENABLE, (ph % 6 == 5) ? 32'd0 : 32'd1);
      burst_left = 0;
      loud = 1'b0;
      for (int k = 0; k < 112; k++) begin
        if (burst_left == 0) begin
          loud = 1'($urandom_range(1));
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        if ($urandom_range(99) < 15) begin
          s = 24'($urandom);
        end else begin
          if (loud) m = 24'($urandom_range(open_thr >> 1, 24'h800000));
          else m = 24'($urandom_range(0, (close_thr >> 2) + 16));
          if (m == 24'h800000 || $urandom_range(1) == 1) s = ~m + 24'd1;
          else s = m;
        end
        send_sample(s);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    out_tready <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    gate_en = 1'b0;
    open_thr = OPEN_THRESH_RST[23:0];
    close_thr = CLOSE_THRESH_RST[23:0];
    atk_coef = ATTACK_COEF_RST[23:0];
    rel_coef = RELEASE_COEF_RST[23:0];
    hold_len = '0;
    gate_reinit();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_passthrough();
    test_gate_defaults();
    test_gate_extremes();
    test_backpressure();
    test_random_program();

    in_tvalid <= 1'b0;
    while (pending_gated.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/agn_pkg.sv
design/agn_regs.sv
design/agn_ctrl.sv
design/agn_dp.sv
design/audio_noise_gate_top.sv
dv/tb_audio_noise_gate_top.sv
